// ----- rtl/core/m3i_pkg.sv -----
// Shared constants, widths and beat types for the 3x3 matrix inverse pipeline.
`timescale 1ns / 1ps
`default_nettype none
package m3i_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int PW   = 2 * DATA_WIDTH;
  localparam int AW   = 2 * DATA_WIDTH + 1;
  localparam int LOW  = DATA_WIDTH + 1;
  localparam int HIW  = AW - LOW;
  localparam int LPW  = DATA_WIDTH + LOW + 1;
  localparam int HPW  = DATA_WIDTH + HIW;
  localparam int DETW = 3 * DATA_WIDTH + 3;
  localparam int FB2  = 2 * FRAC_BITS;
  localparam int QB   = DATA_WIDTH;
  localparam int NUMW = AW + FB2;
  localparam int CW   = ((NUMW > DETW + QB) ? NUMW : DETW + QB) + 2;

  localparam int DET_STAGES  = 5;
  localparam int LANE_STAGES = QB + 4;
  localparam int NSTAGE      = DET_STAGES + LANE_STAGES;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] r00;
    logic signed [DATA_WIDTH-1:0] r01;
    logic signed [DATA_WIDTH-1:0] r02;
    logic signed [DATA_WIDTH-1:0] r10;
    logic signed [DATA_WIDTH-1:0] r11;
    logic signed [DATA_WIDTH-1:0] r12;
    logic signed [DATA_WIDTH-1:0] r20;
    logic signed [DATA_WIDTH-1:0] r21;
    logic signed [DATA_WIDTH-1:0] r22;
    logic                         singular;
  } out_t;

endpackage
`default_nettype wire

// ----- rtl/core/m3i_det.sv -----
// Front pipeline: element products, cofactors and the exact determinant.
`timescale 1ns / 1ps
`default_nettype none
module m3i_det (
  input  wire logic                                    clk,
  input  wire logic [m3i_pkg::DET_STAGES-1:0]          ce,
  input  wire m3i_pkg::in_t                            in_data,
  output logic signed [m3i_pkg::DETW-1:0]              det,
  output logic signed [m3i_pkg::AW-1:0]                cof [3][3],
  output m3i_pkg::elem_t                               elem [3][3]
);

  m3i_pkg::elem_t                     e1_r [3][3];
  m3i_pkg::elem_t                     e2_r [3][3];
  m3i_pkg::elem_t                     e3_r [3][3];
  m3i_pkg::elem_t                     e4_r [3][3];
  m3i_pkg::elem_t                     e5_r [3][3];
  logic signed [m3i_pkg::PW-1:0]      pa_r [3][3];
  logic signed [m3i_pkg::PW-1:0]      pb_r [3][3];
  logic signed [m3i_pkg::AW-1:0]      cp3_r [3][3];
  logic signed [m3i_pkg::AW-1:0]      cp4_r [3][3];
  logic signed [m3i_pkg::AW-1:0]      cp5_r [3][3];
  logic signed [m3i_pkg::LPW-1:0]     lo_r [3];
  logic signed [m3i_pkg::HPW-1:0]     hi_r [3];
  logic signed [m3i_pkg::DETW-1:0]    det_r;
  logic signed [m3i_pkg::DETW-1:0]    det_nxt;

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      e1_r[0][0] <= in_data.m00;
      e1_r[0][1] <= in_data.m01;
      e1_r[0][2] <= in_data.m02;
      e1_r[1][0] <= in_data.m10;
      e1_r[1][1] <= in_data.m11;
      e1_r[1][2] <= in_data.m12;
      e1_r[2][0] <= in_data.m20;
      e1_r[2][1] <= in_data.m21;
      e1_r[2][2] <= in_data.m22;
    end
  end

  // Cofactor row j is row(j+1) x row(j+2).
  for (genvar j = 0; j < 3; j++) begin : g_row
    localparam int RA = (j + 1) % 3;
    localparam int RB = (j + 2) % 3;
    for (genvar k = 0; k < 3; k++) begin : g_col
      localparam int CP = (k + 1) % 3;
      localparam int CS = (k + 2) % 3;
      always_ff @(posedge clk) begin
        if (ce[1]) begin
          pa_r[j][k] <= e1_r[RA][CP] * e1_r[RB][CS];
          pb_r[j][k] <= e1_r[RA][CS] * e1_r[RB][CP];
          e2_r[j][k] <= e1_r[j][k];
        end
        if (ce[2]) begin
          cp3_r[j][k] <= m3i_pkg::AW'(pa_r[j][k]) - m3i_pkg::AW'(pb_r[j][k]);
          e3_r[j][k]  <= e2_r[j][k];
        end
        if (ce[3]) begin
          cp4_r[j][k] <= cp3_r[j][k];
          e4_r[j][k]  <= e3_r[j][k];
        end
        if (ce[4]) begin
          cp5_r[j][k] <= cp4_r[j][k];
          e5_r[j][k]  <= e4_r[j][k];
        end
      end
    end
  end

  // The first-row expansion splits each cofactor into a low unsigned and a high signed half.
  for (genvar k = 0; k < 3; k++) begin : g_part
    always_ff @(posedge clk) begin
      if (ce[3]) begin
        lo_r[k] <= m3i_pkg::LPW'(e3_r[0][k]) *
                   m3i_pkg::LPW'($signed({1'b0, cp3_r[0][k][m3i_pkg::LOW-1:0]}));
        hi_r[k] <= e3_r[0][k] * $signed(cp3_r[0][k][m3i_pkg::AW-1:m3i_pkg::LOW]);
      end
    end
  end

  always_comb begin
    det_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      det_nxt = det_nxt + (m3i_pkg::DETW'(hi_r[k]) <<< m3i_pkg::LOW)
                        + m3i_pkg::DETW'(lo_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce[4]) begin
      det_r <= det_nxt;
    end
  end

  assign det  = det_r;
  assign cof  = cp5_r;
  assign elem = e5_r;

endmodule
`default_nettype wire

// ----- rtl/core/m3i_div_lane.sv -----
// One output element: magnitudes, pipelined restoring division, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none
module m3i_div_lane (
  input  wire logic                                 clk,
  input  wire logic [m3i_pkg::LANE_STAGES-1:0]      ce,
  input  wire logic signed [m3i_pkg::AW-1:0]        adj,
  input  wire logic signed [m3i_pkg::DETW-1:0]      det,
  input  wire m3i_pkg::elem_t                       elem,
  output m3i_pkg::elem_t                            res,
  output logic                                      sing
);

  localparam int QB = m3i_pkg::QB;

  logic                         zero_a_r, neg_a_r;
  logic [m3i_pkg::AW-1:0]       amag_a_r;
  logic [m3i_pkg::DETW-1:0]     dmag_a_r;
  m3i_pkg::elem_t               elem_a_r;

  logic                         zero_b_r, neg_b_r;
  logic [m3i_pkg::CW-1:0]       num_b_r;
  logic [m3i_pkg::DETW:0]       den_b_r;
  m3i_pkg::elem_t               elem_b_r;

  logic [m3i_pkg::CW-1:0]       rem_r  [QB+1];
  logic [QB:0]                  q_r    [QB+1];
  logic [m3i_pkg::DETW:0]       den_r  [QB+1];
  logic                         neg_r  [QB+1];
  logic                         zero_r [QB+1];
  m3i_pkg::elem_t               elem_r [QB+1];

  m3i_pkg::elem_t               res_r;
  logic                         sing_r;

  logic [QB:0]                  lim, qsat, qneg;

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      zero_a_r <= (det == '0);
      neg_a_r  <= adj[m3i_pkg::AW-1] ^ det[m3i_pkg::DETW-1];
      amag_a_r <= adj[m3i_pkg::AW-1] ? m3i_pkg::AW'(-adj) : m3i_pkg::AW'(adj);
      dmag_a_r <= det[m3i_pkg::DETW-1] ? m3i_pkg::DETW'(-det) : m3i_pkg::DETW'(det);
      elem_a_r <= elem;
    end
    if (ce[1]) begin
      // Round to nearest, ties away: (2|adj|*2^2F + |det|) / (2|det|).
      num_b_r  <= (m3i_pkg::CW'({amag_a_r, {m3i_pkg::FB2{1'b0}}}) << 1)
                  + m3i_pkg::CW'(dmag_a_r);
      den_b_r  <= {dmag_a_r, 1'b0};
      zero_b_r <= zero_a_r;
      neg_b_r  <= neg_a_r;
      elem_b_r <= elem_a_r;
    end
  end

  // One quotient bit per stage; the top bit only flags an out-of-range quotient.
  for (genvar g = 0; g <= QB; g++) begin : g_step
    localparam int K = QB - g;
    logic [m3i_pkg::CW-1:0]   rem_in, shd;
    logic [QB:0]              q_in;
    logic [m3i_pkg::DETW:0]   den_in;
    logic                     neg_in, zero_in, take;
    m3i_pkg::elem_t           elem_in;

    if (g == 0) begin : g_first
      assign rem_in  = num_b_r;
      assign q_in    = '0;
      assign den_in  = den_b_r;
      assign neg_in  = neg_b_r;
      assign zero_in = zero_b_r;
      assign elem_in = elem_b_r;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign q_in    = q_r[g-1];
      assign den_in  = den_r[g-1];
      assign neg_in  = neg_r[g-1];
      assign zero_in = zero_r[g-1];
      assign elem_in = elem_r[g-1];
    end

    assign shd  = m3i_pkg::CW'(den_in) << K;
    assign take = (rem_in >= shd);

    always_ff @(posedge clk) begin
      if (ce[2+g]) begin
        rem_r[g]    <= take ? rem_in - shd : rem_in;
        q_r[g]      <= q_in | ((QB+1)'(take) << K);
        den_r[g]    <= den_in;
        neg_r[g]    <= neg_in;
        zero_r[g]   <= zero_in;
        elem_r[g]   <= elem_in;
      end
    end
  end

  always_comb begin
    lim  = neg_r[QB] ? ((QB+1)'(1) << (m3i_pkg::DATA_WIDTH - 1))
                     : ((QB+1)'(1) << (m3i_pkg::DATA_WIDTH - 1)) - (QB+1)'(1);
    qsat = (q_r[QB] > lim) ? lim : q_r[QB];
    qneg = neg_r[QB] ? -qsat : qsat;
  end

  always_ff @(posedge clk) begin
    if (ce[QB+3]) begin
      res_r  <= zero_r[QB] ? elem_r[QB] : $signed(qneg[m3i_pkg::DATA_WIDTH-1:0]);
      sing_r <= zero_r[QB];
    end
  end

  assign res  = res_r;
  assign sing = sing_r;

endmodule
`default_nettype wire

// ----- rtl/core/matrix3_inverse_unit.sv -----
// 3x3 fixed-point matrix inverse by adjugate and determinant, fully pipelined.
//
// Takes one Q16.16 matrix per cycle while in_stall is low and returns its inverse, each
// element rounded to nearest and saturated, after five stages of products, cofactors and
// determinant; two of magnitude and rounding setup; 33 restoring-division stages, one
// quotient bit each; and one output register. The division pipeline makes up most of
// the depth. A matrix with a zero determinant comes back unchanged with singular set.
// A stalled output holds only the stages that are full; bubbles still close up.
`timescale 1ns / 1ps
`default_nettype none
module matrix3_inverse_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire m3i_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output m3i_pkg::out_t      out_data
);

  localparam int NS = m3i_pkg::NSTAGE;

  logic [NS-1:0]                     v_r;
  logic [NS-1:0]                     ce;
  logic signed [m3i_pkg::DETW-1:0]   det;
  logic signed [m3i_pkg::AW-1:0]     cof  [3][3];
  m3i_pkg::elem_t                    elem [3][3];
  m3i_pkg::elem_t                    res  [3][3];
  logic                              sing [3][3];

  // A stage loads unless it and every stage after it is full while the output stalls.
  for (genvar s = 0; s < NS; s++) begin : g_ce
    assign ce[s] = !out_stall || !(&v_r[NS-1:s]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (ce[s]) begin
          v_r[s] <= (s == 0) ? in_valid : v_r[(s == 0) ? 0 : s - 1];
        end
      end
    end
  end

  assign in_stall  = !ce[0];
  assign out_valid = v_r[NS-1];

  m3i_det u_det (
    .clk     (clk),
    .ce      (ce[m3i_pkg::DET_STAGES-1:0]),
    .in_data (in_data),
    .det     (det),
    .cof     (cof),
    .elem    (elem)
  );

  // Inverse element (i,j) is cofactor (j,i) over the determinant.
  for (genvar i = 0; i < 3; i++) begin : g_i
    for (genvar j = 0; j < 3; j++) begin : g_j
      m3i_div_lane u_lane (
        .clk  (clk),
        .ce   (ce[NS-1:m3i_pkg::DET_STAGES]),
        .adj  (cof[j][i]),
        .det  (det),
        .elem (elem[i][j]),
        .res  (res[i][j]),
        .sing (sing[i][j])
      );
    end
  end

  always_comb begin
    out_data.r00      = res[0][0];
    out_data.r01      = res[0][1];
    out_data.r02      = res[0][2];
    out_data.r10      = res[1][0];
    out_data.r11      = res[1][1];
    out_data.r12      = res[1][2];
    out_data.r20      = res[2][0];
    out_data.r21      = res[2][1];
    out_data.r22      = res[2][2];
    out_data.singular = sing[0][0];
  end

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall && out_valid)
    else $error("input stalled without a blocked output");

  a_full_blocked_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && out_stall |-> in_stall)
    else $error("full pipeline accepted a beat under stall");

  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sing[0][0] == sing[2][2] && sing[1][1] == sing[0][2])
    else $error("lanes disagree on singular");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the pipelined 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps
module tb;
  import m3i_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam int IDLE_PCT = 37;
  localparam elem_t ONE = elem_t'(1 << FRAC_BITS);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  out_t inverse_q[$];
  bit no_idle = 1'b0;
  int mismatches = 0;
  int matrices_sent = 0;
  int inverses_seen = 0;
  int singular_seen = 0;

  matrix3_inverse_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Rounded (ties away from zero) and saturated quotient num / den.
  function automatic elem_t round_sat_div(wide_t num, wide_t den);
    logic neg;
    logic [255:0] an, ad, q, lim;
    neg = num[255] ^ den[255];
    an = num[255] ? -num : num;
    ad = den[255] ? -den : den;
    q = (2 * an + ad) / (2 * ad);
    lim = neg ? (256'd1 << (DATA_WIDTH - 1)) : (256'd1 << (DATA_WIDTH - 1)) - 1;
    if (q > lim) q = lim;
    if (neg) q = -q;
    return q[DATA_WIDTH-1:0];
  endfunction

  function automatic out_t invert_matrix(in_t m);
    wide_t e[3][3], cof[3][3], det;
    elem_t r[9];
    out_t res;
    int a, b, p, s;
    e[0][0] = m.m00; e[0][1] = m.m01; e[0][2] = m.m02;
    e[1][0] = m.m10; e[1][1] = m.m11; e[1][2] = m.m12;
    e[2][0] = m.m20; e[2][1] = m.m21; e[2][2] = m.m22;
    // Cofactor row j is the cross product of the two other rows.
    for (int j = 0; j < 3; j++) begin
      a = (j + 1) % 3;
      b = (j + 2) % 3;
      for (int k = 0; k < 3; k++) begin
        p = (k + 1) % 3;
        s = (k + 2) % 3;
        cof[j][k] = e[a][p] * e[b][s] - e[a][s] * e[b][p];
      end
    end
    det = '0;
    for (int k = 0; k < 3; k++) det = det + e[0][k] * cof[0][k];
    if (det == 0) begin
      res = {m, 1'b1};
    end else begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          r[i*3+j] = round_sat_div(cof[j][i] <<< FB2, det);
      res = {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], 1'b0};
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_WIDTH-1:0] got,
                                 logic [DATA_WIDTH-1:0] want);
    $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_matrix(in_t m);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= m;
    do @(posedge clk); while (in_stall);
    inverse_q.push_back(invert_matrix(m));
    matrices_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst_n || no_idle) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    out_t want;
    logic [DATA_WIDTH-1:0] g, w;
    if (rst_n && out_valid && !out_stall) begin
      if (inverse_q.size() == 0) begin
        report_mismatch("unexpected beat, r00", out_data.r00, '0);
      end else begin
        want = inverse_q.pop_front();
        inverses_seen++;
        if (want.singular) singular_seen++;
        for (int i = 0; i < 9; i++) begin
          g = out_data[$bits(out_t)-1-DATA_WIDTH*i -: DATA_WIDTH];
          w = want[$bits(out_t)-1-DATA_WIDTH*i -: DATA_WIDTH];
          if (g !== w) report_mismatch($sformatf("r%0d%0d", i / 3, i % 3), g, w);
        end
        if (out_data.singular !== want.singular)
          report_mismatch("singular", out_data.singular, want.singular);
      end
    end
  end

  function automatic in_t diag(elem_t a, elem_t b, elem_t c);
    return {a, elem_t'(0), elem_t'(0), elem_t'(0), b, elem_t'(0), elem_t'(0), elem_t'(0), c};
  endfunction

  // kind 0: moderate Q16.16 values, 1: any bit pattern, 2: tiny raw values.
  function automatic elem_t rand_elem(int kind);
    case (kind)
      0: return elem_t'($signed($urandom_range(0, 2 << 19)) - (1 << 19));
      1: return elem_t'($urandom);
      default: return elem_t'($signed($urandom_range(0, 512)) - 256);
    endcase
  endfunction

  function automatic in_t rand_matrix(int kind);
    in_t m;
    m = {rand_elem(kind), rand_elem(kind), rand_elem(kind),
         rand_elem(kind), rand_elem(kind), rand_elem(kind),
         rand_elem(kind), rand_elem(kind), rand_elem(kind)};
    return m;
  endfunction

  task automatic test_regular_matrices();
    send_matrix(diag(ONE, ONE, ONE));
    send_matrix(diag(2 * ONE, 2 * ONE, 2 * ONE));
    send_matrix(diag(3 * ONE, -ONE, ONE / 2));
    // A row swap of the identity has a negative determinant.
    send_matrix({elem_t'(0), ONE, elem_t'(0), ONE, elem_t'(0), elem_t'(0),
                 elem_t'(0), elem_t'(0), ONE});
    send_matrix({ONE, 2 * ONE, 3 * ONE, elem_t'(0), ONE, 4 * ONE,
                 5 * ONE, 6 * ONE, elem_t'(0)});
  endtask

  task automatic test_singular_matrices();
    send_matrix('0);
    send_matrix({ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE,
                 7 * ONE, -ONE, 5 * ONE});
    send_matrix({ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                 7 * ONE, 8 * ONE, 9 * ONE});
    send_matrix({9{elem_t'(32'h8000_0000)}});
    send_matrix({9{elem_t'(32'h7fff_ffff)}});
    send_matrix({9{elem_t'(32'hffff_ffff)}});
  endtask

  task automatic test_extremes();
    send_matrix(diag(elem_t'(32'h7fff_ffff), elem_t'(32'h7fff_ffff), elem_t'(32'h7fff_ffff)));
    send_matrix(diag(elem_t'(32'h8000_0000), elem_t'(32'h8000_0000), elem_t'(32'h8000_0000)));
    send_matrix(diag(elem_t'(32'h8000_0000), elem_t'(32'h7fff_ffff), elem_t'(1)));
    // Tiny diagonals push the inverse past full scale in both directions.
    send_matrix(diag(elem_t'(1), elem_t'(1), elem_t'(1)));
    send_matrix(diag(elem_t'(-1), elem_t'(1), elem_t'(1)));
    send_matrix(diag(elem_t'(-1), elem_t'(-1), elem_t'(-1)));
    send_matrix({elem_t'(32'h7fff_ffff), elem_t'(32'h8000_0000), elem_t'(1),
                 elem_t'(-1), elem_t'(32'h7fff_ffff), elem_t'(32'h8000_0000),
                 elem_t'(32'h8000_0000), elem_t'(-1), elem_t'(32'h7fff_ffff)});
  endtask

  task automatic test_random_matrices(int count);
    in_t m;
    int pick;
    for (int n = 0; n < count; n++) begin
      no_idle = (n >= count / 3) && (n < count / 3 + 200);
      pick = $urandom_range(99);
      if (pick < 50) m = rand_matrix(0);
      else if (pick < 70) m = rand_matrix(1);
      else if (pick < 82) m = rand_matrix(2);
      else begin
        // Singular by construction: a repeated, zero or negated row.
        m = rand_matrix($urandom_range(2));
        case ($urandom_range(2))
          0: {m.m20, m.m21, m.m22} = {m.m00, m.m01, m.m02};
          1: {m.m10, m.m11, m.m12} = '0;
          default: {m.m20, m.m21, m.m22} = {-m.m10, -m.m11, -m.m12};
        endcase
      end
      send_matrix(m);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_regular_matrices();
    test_singular_matrices();
    test_extremes();
    test_random_matrices(1800);
    in_valid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d matrices; %0d results checked, %0d of them singular.",
             matrices_sent, inverses_seen, singular_seen);
    $display("Random matrices mixed moderate, full-range, tiny and rank-deficient values.");
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", inverse_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
